### rtl/core/clhf_pkg.sv
`default_nettype none

package clhf_pkg;

    // CRC-32, MSB first, no reflection
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

    // Position of the held item within its run of output bytes
    typedef enum logic [6:0] {
        PH_HDR_HI = 7'b000_0001,
        PH_HDR_LO = 7'b000_0010,
        PH_DATA   = 7'b000_0100,
        PH_CRC0   = 7'b000_1000,
        PH_CRC1   = 7'b001_0000,
        PH_CRC2   = 7'b010_0000,
        PH_CRC3   = 7'b100_0000
    } phase_t;

    // One output byte with its flags
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
        logic       run_last;
    } result_t;

    // Advance the remainder by one byte (eight shift/xor steps)
    function automatic logic [31:0] crc_feed(logic [31:0] rem, logic [7:0] data);
        logic [31:0] r;
        r = rem ^ {data, 24'h0};
        for (int b = 0; b < 8; b++)
        begin
            if (r[31])
            begin
                r = {r[30:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                r = {r[30:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/clhf_in_if.sv
`default_nettype none

// Payload channel: one byte per item, length sampled at frame start
interface clhf_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;

    modport source (output valid, output payload_byte, output payload_length, input ready);
    modport sink   (input valid, input payload_byte, input payload_length, output ready);
endinterface

`default_nettype wire

### rtl/core/clhf_out_if.sv
`default_nettype none

// Frame channel: one frame byte per item
interface clhf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       end_of_frame;
    logic       run_last;

    modport source (output valid, output frame_byte, output end_of_frame, output run_last,
                    input ready);
    modport sink   (input valid, input frame_byte, input end_of_frame, input run_last,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/clhf_seq.sv
`default_nettype none

// Holds one input item and steps through the bytes it causes, one per cycle while res_ready is high
module clhf_seq
    import clhf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    clhf_in_if.sink     item,
    output logic        res_valid,
    output result_t     res,
    input  wire logic   res_ready
);

    logic        hold_valid_reg, hold_valid_next;
    logic [7:0]  byte_reg;
    logic [15:0] len_reg;
    phase_t      phase_reg, phase_next;
    logic [31:0] crc_reg, crc_next;
    logic [15:0] left_reg, left_next;

    logic [15:0] len_eff;
    logic [7:0]  out_byte;
    logic [31:0] crc_step;
    logic [15:0] left_step;
    phase_t      phase_adv;
    logic        done;
    logic        eof;
    logic        emit;
    logic        release_item;
    logic        load;

    // A zero length opens a one-byte frame
    assign len_eff = (len_reg == 16'd0) ? 16'd1 : len_reg;

    // Byte for the current phase
    always_comb
    begin
        out_byte  = byte_reg;
        crc_step  = crc_reg;
        left_step = left_reg;
        phase_adv = phase_reg;
        done      = 1'b0;
        eof       = 1'b0;
        case (phase_reg)
            PH_HDR_HI:
            begin
                out_byte  = len_eff[15:8];
                crc_step  = crc_feed(32'h0, len_eff[15:8]);
                left_step = len_eff;
                phase_adv = PH_HDR_LO;
            end
            PH_HDR_LO:
            begin
                out_byte  = len_eff[7:0];
                crc_step  = crc_feed(crc_reg, len_eff[7:0]);
                phase_adv = PH_DATA;
            end
            PH_DATA:
            begin
                out_byte  = byte_reg;
                crc_step  = crc_feed(crc_reg, byte_reg);
                left_step = left_reg - 16'd1;
                done      = (left_reg != 16'd1);
                phase_adv = PH_CRC0;
            end
            PH_CRC0:
            begin
                out_byte  = crc_reg[31:24];
                phase_adv = PH_CRC1;
            end
            PH_CRC1:
            begin
                out_byte  = crc_reg[23:16];
                phase_adv = PH_CRC2;
            end
            PH_CRC2:
            begin
                out_byte  = crc_reg[15:8];
                phase_adv = PH_CRC3;
            end
            PH_CRC3:
            begin
                out_byte = crc_reg[7:0];
                crc_step = 32'h0;
                done     = 1'b1;
                eof      = 1'b1;
            end
            default:
            begin
                out_byte = byte_reg;
                done     = 1'b1;
            end
        endcase
    end

    // Handshakes
    assign emit         = hold_valid_reg && res_ready;
    assign release_item = emit && done;
    assign item.ready   = !hold_valid_reg || release_item;
    assign load         = item.valid && item.ready;

    assign res_valid        = hold_valid_reg;
    assign res.frame_byte   = out_byte;
    assign res.end_of_frame = eof;
    assign res.run_last     = done;

    // Next state
    always_comb
    begin
        crc_next  = emit ? crc_step : crc_reg;
        left_next = emit ? left_step : left_reg;

        if (load)
        begin
            hold_valid_next = 1'b1;
        end
        else if (release_item)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end

        // New item opens a frame when none is open after this cycle
        if (load)
        begin
            phase_next = (left_next == 16'd0) ? PH_HDR_HI : PH_DATA;
        end
        else if (emit && !done)
        begin
            phase_next = phase_adv;
        end
        else
        begin
            phase_next = phase_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= PH_HDR_HI;
            crc_reg        <= 32'h0;
            left_reg       <= 16'd0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
            crc_reg        <= crc_next;
            left_reg       <= left_next;
        end
    end

    // Held item
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= item.payload_byte;
            len_reg  <= item.payload_length;
        end
    end

endmodule

`default_nettype wire

### rtl/core/clhf_out_reg.sv
`default_nettype none

// Output register: holds a finished byte until the sink takes it
module clhf_out_reg
    import clhf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   res_valid,
    input  wire result_t res,
    output logic        res_ready,
    clhf_out_if.source  frame
);

    logic    valid_reg, valid_next;
    result_t data_reg;
    logic    load;

    assign res_ready = !valid_reg || frame.ready;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (frame.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign frame.valid        = valid_reg;
    assign frame.frame_byte   = data_reg.frame_byte;
    assign frame.end_of_frame = data_reg.end_of_frame;
    assign frame.run_last     = data_reg.run_last;

endmodule

`default_nettype wire

### rtl/core/crc32_length_header_framer.sv
// Channel   Direction  Fields
// payload   in         payload_byte[7:0], payload_length[15:0]
// frame     out        frame_byte[7:0], end_of_frame, run_last
//
// One output byte per cycle, set by the single frame byte port, while frame.ready
// is high. A mid-frame payload item yields one byte; the first item of a frame
// yields three (two header bytes), the last five (four CRC bytes), a one-byte frame seven.
// Reset clears the open frame and the CRC; first item after reset opens a frame.
// Output stalls back up through one output register and one held input item.
`default_nettype none

module crc32_length_header_framer
    import clhf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    clhf_in_if.sink     payload,
    clhf_out_if.source  frame
);

    logic    res_valid;
    logic    res_ready;
    result_t res;

    // Byte sequencer with CRC
    clhf_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (payload),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // Output register
    clhf_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .frame     (frame)
    );

endmodule

`default_nettype wire

### rtl/core/clhf_checker.sv
`default_nettype none

// Port-level checks on the framer
module clhf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_eof,
    input wire logic       out_last
);

    // Stalled output holds
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("frame valid dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(out_eof) && $stable(out_last))
        else $error("frame payload changed while stalled");

    // Final CRC byte always closes the item's run
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_eof |-> out_last)
        else $error("end_of_frame without run_last");

    // Input is only held off while bytes are on their way out
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> out_valid)
        else $error("input held off with no output pending");

endmodule

bind crc32_length_header_framer clhf_checker u_clhf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (payload.ready),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .out_byte  (frame.frame_byte),
    .out_eof   (frame.end_of_frame),
    .out_last  (frame.run_last)
);

`default_nettype wire
